### hdl/mts_pkg.sv
// shared types and constants for the max tracking stack
package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int SCORE_W     = 31;
    localparam int FILL_W      = 9;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ID_W-1:0]    player_id;
        logic [SCORE_W-1:0] score;
    } mts_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    top_id;
        logic [SCORE_W-1:0] top_score;
        logic [FILL_W-1:0]  fill;
    } mts_out_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } mts_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        mts_entry_t        data;
    } mts_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mts_rd_t;

endpackage

### hdl/mts_store.sv
// entry memory: one write port, one read port with registered read data
module mts_store (
    input  logic               clk,
    input  mts_pkg::mts_wr_t   wr,
    input  mts_pkg::mts_rd_t   rd,
    output mts_pkg::mts_entry_t rd_data
);
    import mts_pkg::*;

    mts_entry_t mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

### hdl/max_tracking_stack.sv
// max tracking stack: control, top-of-stack copy and result register
//
//  channel  signals               transfer
//  item     start, busy, item     start high and busy low at a rising edge
//  result   done, result          done high for one cycle, always taken
//
// push, peek and a pop that leaves no entries keep busy low: the next item
// may follow at once; a pop that leaves entries raises busy for one cycle
// while the new top is read back from the entry memory
// a result is on the ports in the cycle after its accepting edge, or after
// the S_POP state for a pop that leaves entries; the receiver never stalls results
// reset clears the fill count and the control state; memory is not cleared
module max_tracking_stack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mts_pkg::mts_in_t  item,
    output logic              done,
    output mts_pkg::mts_out_t result
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    mts_entry_t top_reg, top_next;
    logic       done_reg, done_next;
    mts_out_t   result_reg, result_next;

    mts_wr_t    wr;
    mts_rd_t    rd;
    mts_entry_t rd_data;
    mts_entry_t push_entry;
    logic       accept;

    mts_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg == S_POP);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        if (count_reg == '0 || item.score >= top_reg.score)
        begin
            push_entry.id    = item.player_id;
            push_entry.score = item.score;
        end
        else
        begin
            push_entry = top_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr.en       = 1'b0;
        wr.addr     = count_reg[ADDR_W-1:0];
        wr.data     = push_entry;
        rd.en       = 1'b0;
        rd.addr     = ADDR_W'(count_reg - CNT_W'(2));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    result_next.status    = ST_OK;
                    result_next.top_id    = top_reg.id;
                    result_next.top_score = top_reg.score;
                    result_next.fill      = FILL_W'(count_reg);
                    case (item.mode)
                        MODE_PUSH:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                top_next   = push_entry;
                                count_next = count_reg + CNT_W'(1);
                                result_next.top_id    = push_entry.id;
                                result_next.top_score = push_entry.score;
                                result_next.fill      = FILL_W'(count_reg + CNT_W'(1));
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status    = ST_EMPTY;
                                result_next.top_id    = '0;
                                result_next.top_score = '0;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                count_next            = '0;
                                result_next.top_id    = '0;
                                result_next.top_score = '0;
                                result_next.fill      = '0;
                            end
                            else
                            begin
                                // new top comes back from memory next cycle
                                done_next  = 1'b0;
                                rd.en      = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status    = ST_EMPTY;
                                result_next.top_id    = '0;
                                result_next.top_score = '0;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                top_next              = rd_data;
                done_next             = 1'b1;
                result_next.status    = ST_OK;
                result_next.top_id    = rd_data.id;
                result_next.top_score = rd_data.score;
                result_next.fill      = FILL_W'(count_reg);
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        result_reg <= result_next;
    end

endmodule
